/* rtl/fpst_pkg.sv */
// Shared types and constants for the Fenwick prefix-sum table.
// Depends on nothing; used by every module of the block.
package fpst_pkg;

    localparam int POS_W             = 11;
    localparam int DATA_W            = 32;
    // Update walk can step past the limit by up to one lowbit: 2*2047 fits 12 bits.
    localparam int WALK_W            = POS_W + 1;
    localparam int DEF_MAX_POSITIONS = 1024;
    localparam int APB_AW            = 3;

    localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic REG_SIZE_IN_USE = 1'b0;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] delta;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] prefix_sum;
        logic                     status;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] data;
    } t_wr_ctl;

endpackage

/* rtl/fpst_mem.sv */
// Single-port-write, single-port-read synchronous RAM holding the tree nodes.
// Read data is registered. Depends on fpst_pkg.
module fpst_mem #(
    parameter int MAX_POSITIONS = fpst_pkg::DEF_MAX_POSITIONS
) (
    input  logic                             i_clk,
    input  fpst_pkg::t_wr_ctl                i_wr,
    input  logic [$clog2(MAX_POSITIONS)-1:0] i_wr_addr,
    input  logic                             i_rd_en,
    input  logic [$clog2(MAX_POSITIONS)-1:0] i_rd_addr,
    output logic [fpst_pkg::DATA_W-1:0]      o_rd_data
);

    logic [fpst_pkg::DATA_W-1:0] r_mem [MAX_POSITIONS];
    logic [fpst_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/fpst_walk.sv */
// Walk sequencer: clearing pass, range checks, update/query tree walks and
// the result register. Drives the node RAM. Depends on fpst_pkg.
module fpst_walk #(
    parameter int MAX_POSITIONS = fpst_pkg::DEF_MAX_POSITIONS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [fpst_pkg::POS_W-1:0]       i_limit,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  fpst_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output fpst_pkg::t_out_item              o_out_item,
    output fpst_pkg::t_wr_ctl                o_wr,
    output logic [$clog2(MAX_POSITIONS)-1:0] o_wr_addr,
    output logic                             o_rd_en,
    output logic [$clog2(MAX_POSITIONS)-1:0] o_rd_addr,
    input  logic [fpst_pkg::DATA_W-1:0]      i_rd_data
);

    localparam int AW     = $clog2(MAX_POSITIONS);
    localparam int WALK_W = fpst_pkg::WALK_W;
    localparam int POS_W  = fpst_pkg::POS_W;
    localparam int DATA_W = fpst_pkg::DATA_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic                r_op;
    logic [WALK_W-1:0]   r_x;
    logic [DATA_W-1:0]   r_delta;
    logic [POS_W-1:0]    r_limit;
    logic [DATA_W-1:0]   r_sum;
    logic                r_err;
    logic                r_out_valid;
    fpst_pkg::t_out_item r_out_item;

    logic              in_fire;
    logic              in_bad;
    logic              in_walk;
    logic [WALK_W-1:0] in_pos;
    logic [WALK_W-1:0] in_pos_m1;
    logic [WALK_W-1:0] x_low;
    logic [WALK_W-1:0] x_up;
    logic [WALK_W-1:0] x_dn;
    logic [WALK_W-1:0] x_next;
    logic [WALK_W-1:0] x_m1;
    logic [WALK_W-1:0] x_next_m1;
    logic              walk_more;
    logic              out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_pos     = {1'b0, i_in_item.position};
    assign in_pos_m1  = in_pos - WALK_W'(1);

    always_comb begin
        if (i_in_item.operation == fpst_pkg::OP_UPDATE) begin
            in_bad = (i_in_item.position == '0) || (i_in_item.position > i_limit);
        end else begin
            in_bad = (i_in_item.position > i_limit);
        end
    end
    assign in_walk = !in_bad && (i_in_item.position != '0);

    // lowbit step; up for update, down for query
    assign x_low     = r_x & (~r_x + WALK_W'(1));
    assign x_up      = r_x + x_low;
    assign x_dn      = r_x - x_low;
    assign x_next    = (r_op == fpst_pkg::OP_UPDATE) ? x_up : x_dn;
    assign x_m1      = r_x - WALK_W'(1);
    assign x_next_m1 = x_next - WALK_W'(1);
    assign walk_more = (r_op == fpst_pkg::OP_UPDATE) ? (x_up <= {1'b0, r_limit})
                                                     : (x_dn != '0);

    // next node is read while the current one is written; addresses never match
    assign o_rd_en   = (in_fire && in_walk) || ((r_state == S_WALK) && walk_more);
    assign o_rd_addr = (r_state == S_WALK) ? AW'(x_next_m1) : AW'(in_pos_m1);

    always_comb begin
        o_wr.en   = 1'b0;
        o_wr.data = '0;
        o_wr_addr = r_clr_addr;
        if (r_state == S_CLEAR) begin
            o_wr.en = 1'b1;
        end else if ((r_state == S_WALK) && (r_op == fpst_pkg::OP_UPDATE)) begin
            o_wr.en   = 1'b1;
            o_wr.data = i_rd_data + r_delta;
            o_wr_addr = AW'(x_m1);
        end
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:  if (in_fire) n_state = in_walk ? S_WALK : S_DONE;
            S_WALK:  if (!walk_more) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_in_item.operation;
            r_delta <= i_in_item.delta;
            r_limit <= i_limit;
            r_x     <= in_pos;
            r_sum   <= '0;
            r_err   <= in_bad;
        end else if (r_state == S_WALK) begin
            r_x <= x_next;
            if (r_op == fpst_pkg::OP_QUERY) begin
                r_sum <= r_sum + i_rd_data;
            end
        end
        if (out_load) begin
            r_out_item.prefix_sum <= r_sum;
            r_out_item.status     <= r_err ? fpst_pkg::STATUS_RANGE : fpst_pkg::STATUS_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/fenwick_prefix_sum_table.sv */
// Channel    Dir  Handshake                 Payload
// in         in   i_in_valid / o_in_ready   i_in_item  (fpst_pkg::t_in_item)
// out        out  o_out_valid / i_out_ready o_out_item (fpst_pkg::t_out_item)
// config     in   APB psel/penable/pwrite   size_in_use at byte address 0
//
// An item with n tree nodes on its walk visits them one node per cycle through the RAM
// port; n is at most clog2(size)+1 (11 at 1024). Range errors and queries at 0 skip
// the walk. Sync reset starts a clearing pass over all MAX_POSITIONS nodes during which
// no item is taken; config writes still go through.
// A stalled result sits in the output register while the next item is taken.
//
// Top level: config register and limit clamp; holds walk sequencer and node RAM.
// Depends on fpst_pkg, fpst_mem, fpst_walk.
module fenwick_prefix_sum_table #(
    parameter int MAX_POSITIONS = fpst_pkg::DEF_MAX_POSITIONS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fpst_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fpst_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpst_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW    = $clog2(MAX_POSITIONS);
    localparam int POS_W = fpst_pkg::POS_W;

    logic [POS_W-1:0]            r_size;
    logic [POS_W-1:0]            limit;
    logic                        reg_hit;
    fpst_pkg::t_wr_ctl           wr;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [fpst_pkg::DATA_W-1:0] rd_data;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == fpst_pkg::REG_SIZE_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= fpst_pkg::SIZE_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_size <= pwdata[POS_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(32 - POS_W){1'b0}}, r_size} : '0;

    // size above capacity acts as capacity
    assign limit = ({{(32 - POS_W){1'b0}}, r_size} > 32'(MAX_POSITIONS)) ?
                   POS_W'(MAX_POSITIONS) : r_size;

    fpst_walk #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (limit),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_wr        (wr),
        .o_wr_addr   (wr_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    fpst_mem #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

/* rtl/fpst_checker.sv */
// Port-level checks for the Fenwick prefix-sum table, bound to the top level.
// Depends on fpst_pkg and fenwick_prefix_sum_table.
module fpst_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input fpst_pkg::t_out_item         o_out_item
);

    // a result waiting for the sink keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // flagged items carry a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == fpst_pkg::STATUS_RANGE)
        |-> (o_out_item.prefix_sum == '0))
        else $error("error result with nonzero sum");

    // reset starts the clearing pass: nothing taken, nothing shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block active right after reset");

    // one item at a time: busy the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while walking");

endmodule

bind fenwick_prefix_sum_table fpst_checker u_fpst_checker (.*);
